[sv/bfl_pkg.sv]
// Shared constants and types for the RGB565 line box filter.
// No dependencies; imported by box_filter_rgb565_line.
package bfl_pkg;

  localparam int MAX_TAPS = 8;
  localparam int MAX_LINE = 4096;

  localparam int TAP_IDX_W = $clog2(MAX_TAPS);
  localparam int POS_W     = $clog2(MAX_LINE);
  localparam int LEN_W     = 13;

  // register indexes on the config port
  localparam logic [3:0] CFG_TAP_SELECT  = 4'd0;
  localparam logic [3:0] CFG_LINE_LENGTH = 4'd1;

  // tap selector codes
  localparam logic [1:0] TAPS_2 = 2'd0;
  localparam logic [1:0] TAPS_4 = 2'd1;

  typedef logic [15:0] pixel_t;

  // one result beat waiting in the output queue
  typedef struct packed {
    pixel_t pix;
    logic   line_end;
  } result_t;

endpackage

[sv/box_filter_rgb565_line.sv]
// RGB565 moving-average box filter over one line: window regs, running sums,
// 2-entry result queue. Depends on bfl_pkg.
//
// Usage: one pixel beat in, one pixel beat out, in line order. A beat is
// registered at the input, filtered against the running red/green/blue
// sums and the 8-entry pixel history, and written to a two-entry result
// queue; a new beat is taken every cycle while the queue has room and no
// tail read-out is running. Results trail the input by taps/2-1 pixels;
// the last pixel of a line releases the remaining taps/2 pixels: one from
// the filter path and taps/2 - 1 (0, 1 or 3) that the tail sequencer reads
// out of the history one per cycle while the queue has room. The first and
// last taps/2 pixels pass through unchanged; a line shorter than taps
// passes through with no delay. Config writes are accepted at any time
// (cfg_ready is always high) but are meant for an idle block; each one
// restarts the line.
module box_filter_rgb565_line
  import bfl_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // pixel input
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [15:0]  in_pixel_in,
  // result output
  output logic         out_valid,
  input  logic         out_ready,
  output logic [15:0]  out_pixel_out,
  output logic         out_line_end,
  // configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [3:0]   cfg_index,
  input  logic [12:0]  cfg_data
);

  // configuration
  logic [1:0]       tap_sel_r;
  logic [LEN_W-1:0] line_len_r;

  // input register
  logic   in_v_r;
  pixel_t in_pix_r;

  // window state
  pixel_t           hist_r [MAX_TAPS];
  logic [7:0]       red_sum_r, red_sum_nxt;
  logic [8:0]       grn_sum_r, grn_sum_nxt;
  logic [7:0]       blu_sum_r, blu_sum_nxt;
  logic [POS_W-1:0] pos_r;

  // line-end tail sequencer
  logic                 flush_act_r;
  logic [TAP_IDX_W-1:0] flush_k_r;
  logic [TAP_IDX_W-1:0] flush_base_r;

  // result queue
  result_t    q_ent_r [2];
  logic       q_wr_r, q_rd_r;
  logic [1:0] q_cnt_r;

  // decoded window length
  logic [3:0]           taps;
  logic [TAP_IDX_W-1:0] half;
  logic [TAP_IDX_W-1:0] mask;
  logic [1:0]           shamt;
  logic [LEN_W-1:0]     len_eff;

  always_comb begin
    case (tap_sel_r)
      TAPS_2: begin
        taps  = 4'd2;
        shamt = 2'd1;
      end
      TAPS_4: begin
        taps  = 4'd4;
        shamt = 2'd2;
      end
      default: begin
        taps  = 4'd8;
        shamt = 2'd3;
      end
    endcase
    half = taps[TAP_IDX_W:1];
    mask = TAP_IDX_W'(taps - 4'd1);
  end

  // line length zero acts as one pixel, overlong acts as MAX_LINE
  always_comb begin
    if (line_len_r == '0)
      len_eff = LEN_W'(1);
    else if (line_len_r > LEN_W'(MAX_LINE))
      len_eff = LEN_W'(MAX_LINE);
    else
      len_eff = line_len_r;
  end

  // handshakes
  logic q_space, proc, flush_push, push, pop;

  assign q_space    = (q_cnt_r != 2'd2);
  assign proc       = in_v_r && !flush_act_r && q_space;
  assign flush_push = flush_act_r && q_space;
  assign in_ready   = !in_v_r || proc;
  assign cfg_ready  = 1'b1;
  assign out_valid  = (q_cnt_r != 2'd0);
  assign pop        = out_valid && out_ready;

  // per-pixel filter step
  logic [LEN_W-1:0]     n_p1;
  logic                 last, short_line, interior, emit_main, start_flush;
  logic                 first_fill, line_start;
  logic [TAP_IDX_W-1:0] slot, rd_idx;
  pixel_t               old_pix, pass_pix, avg_pix, main_pix;
  logic                 main_end;
  logic [8:0]           red_rnd, blu_rnd;
  logic [9:0]           grn_rnd;

  always_comb begin
    n_p1       = LEN_W'(pos_r) + LEN_W'(1);
    last       = (n_p1 >= len_eff);
    line_start = (pos_r == '0);
    short_line = (len_eff < LEN_W'(taps));
    slot       = pos_r[TAP_IDX_W-1:0] & mask;
    // slots not yet written in this line count as zero
    first_fill = (LEN_W'(pos_r) < LEN_W'(taps));
    old_pix    = first_fill ? '0 : hist_r[slot];

    red_sum_nxt = (line_start ? 8'd0 : red_sum_r) - 8'(old_pix[15:11])
                  + 8'(in_pix_r[15:11]);
    grn_sum_nxt = (line_start ? 9'd0 : grn_sum_r) - 9'(old_pix[10:5])
                  + 9'(in_pix_r[10:5]);
    blu_sum_nxt = (line_start ? 8'd0 : blu_sum_r) - 8'(old_pix[4:0])
                  + 8'(in_pix_r[4:0]);

    // rounded average, taps is a power of two
    red_rnd = (9'(red_sum_nxt) + 9'(half)) >> shamt;
    grn_rnd = (10'(grn_sum_nxt) + 10'(half)) >> shamt;
    blu_rnd = (9'(blu_sum_nxt) + 9'(half)) >> shamt;
    avg_pix = {red_rnd[4:0], grn_rnd[5:0], blu_rnd[4:0]};

    // edge pixel taps/2-1 behind the input, bypassing this cycle's write
    rd_idx   = (pos_r[TAP_IDX_W-1:0] - (half - TAP_IDX_W'(1))) & mask;
    pass_pix = (rd_idx == slot) ? in_pix_r : hist_r[rd_idx];

    interior    = (n_p1 >= LEN_W'({half, 1'b0})) && !last;
    emit_main   = short_line || (n_p1 >= LEN_W'(half));
    start_flush = !short_line && last && (half >= TAP_IDX_W'(2));

    if (short_line) begin
      main_pix = in_pix_r;
      main_end = last;
    end else begin
      main_pix = interior ? avg_pix : pass_pix;
      main_end = last && (half == TAP_IDX_W'(1));
    end
  end

  // tail read-out
  logic [TAP_IDX_W-1:0] flush_idx;
  result_t              push_ent;

  always_comb begin
    flush_idx = (flush_base_r - flush_k_r) & mask;
    push      = (proc && emit_main) || flush_push;
    if (flush_push) begin
      push_ent.pix      = hist_r[flush_idx];
      push_ent.line_end = (flush_k_r == '0);
    end else begin
      push_ent.pix      = main_pix;
      push_ent.line_end = main_end;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_sel_r   <= TAPS_2;
      line_len_r  <= LEN_W'(MAX_LINE);
      in_v_r      <= 1'b0;
      pos_r       <= '0;
      flush_act_r <= 1'b0;
      q_wr_r      <= 1'b0;
      q_rd_r      <= 1'b0;
      q_cnt_r     <= 2'd0;
    end else begin
      if (in_ready)
        in_v_r <= in_valid;

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TAP_SELECT)
          tap_sel_r <= cfg_data[1:0];
        else if (cfg_index == CFG_LINE_LENGTH)
          line_len_r <= cfg_data;
        pos_r <= '0;
      end else if (proc) begin
        pos_r <= last ? '0 : pos_r + POS_W'(1);
      end

      if (proc && start_flush) begin
        flush_act_r <= 1'b1;
      end else if (flush_push && flush_k_r == '0) begin
        flush_act_r <= 1'b0;
      end

      if (push)
        q_wr_r <= !q_wr_r;
      if (pop)
        q_rd_r <= !q_rd_r;
      q_cnt_r <= q_cnt_r + 2'(push) - 2'(pop);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready)
      in_pix_r <= in_pixel_in;
    if (proc) begin
      hist_r[slot] <= in_pix_r;
      red_sum_r    <= red_sum_nxt;
      grn_sum_r    <= grn_sum_nxt;
      blu_sum_r    <= blu_sum_nxt;
    end
    if (proc && start_flush) begin
      flush_k_r    <= half - TAP_IDX_W'(2);
      flush_base_r <= pos_r[TAP_IDX_W-1:0];
    end else if (flush_push) begin
      flush_k_r <= flush_k_r - TAP_IDX_W'(1);
    end
    if (push)
      q_ent_r[q_wr_r] <= push_ent;
  end

  assign out_pixel_out = q_ent_r[q_rd_r].pix;
  assign out_line_end  = q_ent_r[q_rd_r].line_end;

  // checks
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= 2'd2)
    else $error("result queue count out of range");

  a_flush_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(flush_act_r) |-> $past(proc && last))
    else $error("tail read-out started without a line-ending beat");

  a_no_proc_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
    flush_act_r |=> $stable(pos_r) || !$past(flush_act_r) || $past(cfg_valid))
    else $error("line position moved during tail read-out");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    LEN_W'(pos_r) < len_eff || $past(cfg_valid))
    else $error("line position beyond line length");

endmodule
